### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while in reset.
`define WHPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Assert that an expression never holds.
`define WHPQ_NEVER(lbl, expr) \
  `WHPQ_ASSERT(lbl, !(expr))

`endif

### hw/rtl/whpq_pkg.sv
// ----------------------------------------------------------------------------
// whpq_pkg
// Types, codes and defaults of the weak heap priority queue.
// ----------------------------------------------------------------------------
package whpq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int KEY_W_DEF = 32;
  localparam int CAP_W     = 11;
  localparam int CFG_IDX_W = 4;

  localparam logic [CAP_W-1:0] CAP_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIGNED = 4'd1;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXTRACT = 2'd1;
  localparam logic [1:0] REQ_LOAD    = 2'd2;
  localparam logic [1:0] REQ_BUILD   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_in;
  } in_t;

  typedef struct packed {
    logic [31:0]      key_out;
    logic [1:0]       status;
    logic [CAP_W-1:0] count_out;
  } out_t;

endpackage

### hw/rtl/whpq_ram.sv
// ----------------------------------------------------------------------------
// whpq_ram
// Generic RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module whpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/weak_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// weak_heap_priority_queue
// Min weak heap of keys held in a key RAM and a reverse bit RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// shows on out_data for one cycle with out_valid, and the receiver cannot
// stall it. Busy drops in the cycle the result shows, so the next request may
// be taken then. Time per request is set by the read-modify-write joins on
// the key RAM (one read port, one write port, registered read): a join reads
// the ancestor key and the child reverse bit, then the child key, compares
// them and, only when it swaps, writes the ancestor and then the child. A
// refusal, a load or a build of an empty heap finishes without a join. An
// insert writes the key, clears the parent reverse bit for an even index,
// searches its distinguished ancestor by reverse bit reads, and joins upward
// until a join does not swap or the root is reached. An extract reads the
// root, walks the left spine, moves the last key to the root and joins each
// spine node with the root. A build clears every reverse bit, then joins each
// entry from the last down to 1 with its ancestor.
module weak_heap_priority_queue #(
  parameter int HEAP_DEPTH = whpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = whpq_pkg::KEY_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  whpq_pkg::in_t                  in_data,
  output logic                           out_valid,
  output whpq_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [whpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [whpq_pkg::CAP_W-1:0]     cfg_data
);

  import whpq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 1;
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int KX = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;
  localparam int SN = 19;

  typedef enum logic [SN-1:0] {
    S_IDLE = SN'(1) << 0,
    S_IWR  = SN'(1) << 1,
    S_IPAR = SN'(1) << 2,
    S_DA   = SN'(1) << 3,
    S_DAW  = SN'(1) << 4,
    S_XRD  = SN'(1) << 5,
    S_XCAP = SN'(1) << 6,
    S_SP   = SN'(1) << 7,
    S_SPW  = SN'(1) << 8,
    S_MVR  = SN'(1) << 9,
    S_MVW  = SN'(1) << 10,
    S_EL   = SN'(1) << 11,
    S_BCLR = SN'(1) << 12,
    S_BJ   = SN'(1) << 13,
    S_JRD  = SN'(1) << 14,
    S_JRC  = SN'(1) << 15,
    S_JCMP = SN'(1) << 16,
    S_JWD  = SN'(1) << 17,
    S_JWC  = SN'(1) << 18
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            req_r, req_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic                  sgn_r, sgn_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         cur_r, cur_nxt;
  logic [AW-1:0]         anc_r, anc_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [KEY_WIDTH-1:0]  kd_r, kd_nxt;
  logic [KEY_WIDTH-1:0]  kc_r, kc_nxt;
  logic [KEY_WIDTH-1:0]  kout_r, kout_nxt;
  logic                  rc_r, rc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic                  k_we, k_re, r_we, r_re, r_wd, r_rd;
  logic [AW-1:0]         k_wa, k_ra, r_wa, r_ra;
  logic [KEY_WIDTH-1:0]  k_wd, k_rd;

  logic [KX-1:0]         kin_x;
  logic [MW-1:0]         eff_cap;
  logic                  full;
  logic [AW-1:0]         fast_anc;
  logic                  j_done, j_swp, fin;
  logic [1:0]            fin_st;

  function automatic logic key_le(input logic [KEY_WIDTH-1:0] a,
                                  input logic [KEY_WIDTH-1:0] b,
                                  input logic                 s);
    logic [KEY_WIDTH-1:0] x;
    logic [KEY_WIDTH-1:0] y;
    x = a;
    y = b;
    x[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ s;
    y[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ s;
    return x <= y;
  endfunction

  whpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(HEAP_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_wa),
    .wdata (k_wd),
    .re    (k_re),
    .raddr (k_ra),
    .rdata (k_rd)
  );

  whpq_ram #(.WIDTH(1), .DEPTH(HEAP_DEPTH)) u_rev_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_wa),
    .wdata (r_wd),
    .re    (r_re),
    .raddr (r_ra),
    .rdata (r_rd)
  );

  assign kin_x   = KX'(in_data.key_in);
  assign eff_cap = (MW'(cap_r) > MW'(HEAP_DEPTH)) ? MW'(HEAP_DEPTH) : MW'(cap_r);
  assign full    = MW'(cnt_r) >= eff_cap;

  // bits above the lowest set bit of the build index
  always_comb begin
    fast_anc = '0;
    for (int j = 0; j < AW; j++) begin
      if (idx_r[j] && ((idx_r[AW-1:0] & ((AW'(1) << j) - AW'(1))) == '0)) begin
        fast_anc = fast_anc | AW'(idx_r[AW-1:0] >> (j + 1));
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cap_nxt       = cap_r;
    sgn_nxt       = sgn_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    anc_nxt       = anc_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    key_nxt       = key_r;
    kd_nxt        = kd_r;
    kc_nxt        = kc_r;
    kout_nxt      = kout_r;
    rc_nxt        = rc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    k_we = 1'b0;
    k_wa = cur_r;
    k_wd = kd_r;
    k_re = 1'b0;
    k_ra = anc_r;
    r_we = 1'b0;
    r_wa = cur_r;
    r_wd = 1'b0;
    r_re = 1'b0;
    r_ra = cur_r;
    j_done = 1'b0;
    j_swp  = 1'b0;
    fin    = 1'b0;
    fin_st = ST_DONE;

    if (cfg_valid) begin
      case (cfg_index)
        REG_CAPACITY:   cap_nxt = cfg_data;
        REG_KEY_SIGNED: sgn_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_data.req_type;
          key_nxt  = kin_x[KEY_WIDTH-1:0];
          kout_nxt = '0;
          case (in_data.req_type)
            REQ_INSERT, REQ_LOAD: begin
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else begin
                cur_nxt   = cnt_r[AW-1:0];
                state_nxt = S_IWR;
              end
            end
            REQ_EXTRACT: begin
              if (cnt_r == '0) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                state_nxt = S_XRD;
              end
            end
            default: begin
              idx_nxt = '0;
              if (cnt_r == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_BCLR;
              end
            end
          endcase
        end
      end
      S_IWR: begin
        k_we    = 1'b1;
        k_wa    = cur_r;
        k_wd    = key_r;
        r_we    = 1'b1;
        r_wa    = cur_r;
        r_wd    = 1'b0;
        cnt_nxt = cnt_r + CW'(1);
        idx_nxt = IW'(cur_r);
        if (req_r == REQ_LOAD || cur_r == '0) begin
          fin = 1'b1;
        end else if (!cur_r[0]) begin
          state_nxt = S_IPAR;
        end else begin
          state_nxt = S_DA;
        end
      end
      S_IPAR: begin
        r_we      = 1'b1;
        r_wa      = cur_r >> 1;
        r_wd      = 1'b0;
        state_nxt = S_DA;
      end
      S_DA: begin
        if (idx_r > IW'(1)) begin
          r_re      = 1'b1;
          r_ra      = AW'(idx_r >> 1);
          state_nxt = S_DAW;
        end else begin
          anc_nxt   = AW'(idx_r >> 1);
          state_nxt = S_JRD;
        end
      end
      S_DAW: begin
        if (idx_r[0] == r_rd) begin
          idx_nxt   = idx_r >> 1;
          state_nxt = S_DA;
        end else begin
          anc_nxt   = AW'(idx_r >> 1);
          state_nxt = S_JRD;
        end
      end
      S_XRD: begin
        k_re      = 1'b1;
        k_ra      = '0;
        r_re      = 1'b1;
        r_ra      = '0;
        state_nxt = S_XCAP;
      end
      S_XCAP: begin
        kout_nxt = k_rd;
        cnt_nxt  = cnt_r - CW'(1);
        idx_nxt  = IW'(!r_rd);
        last_nxt = '0;
        if (cnt_r == CW'(1)) begin
          fin = 1'b1;
        end else begin
          state_nxt = S_SP;
        end
      end
      S_SP: begin
        if (idx_r < IW'(cnt_r)) begin
          last_nxt  = idx_r[AW-1:0];
          r_re      = 1'b1;
          r_ra      = idx_r[AW-1:0];
          state_nxt = S_SPW;
        end else begin
          state_nxt = S_MVR;
        end
      end
      S_SPW: begin
        idx_nxt   = {idx_r[IW-2:0], r_rd};
        state_nxt = S_SP;
      end
      S_MVR: begin
        k_re      = 1'b1;
        k_ra      = cnt_r[AW-1:0];
        state_nxt = S_MVW;
      end
      S_MVW: begin
        k_we      = 1'b1;
        k_wa      = '0;
        k_wd      = k_rd;
        idx_nxt   = IW'(last_r);
        state_nxt = S_EL;
      end
      S_EL: begin
        if (idx_r != '0) begin
          anc_nxt   = '0;
          cur_nxt   = idx_r[AW-1:0];
          state_nxt = S_JRD;
        end else begin
          fin = 1'b1;
        end
      end
      S_BCLR: begin
        r_we = 1'b1;
        r_wa = idx_r[AW-1:0];
        r_wd = 1'b0;
        if (idx_r + IW'(1) == IW'(cnt_r)) begin
          if (cnt_r > CW'(1)) begin
            idx_nxt   = IW'(cnt_r) - IW'(1);
            state_nxt = S_BJ;
          end else begin
            fin = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_BJ: begin
        if (idx_r != '0) begin
          cur_nxt   = idx_r[AW-1:0];
          anc_nxt   = fast_anc;
          state_nxt = S_JRD;
        end else begin
          fin = 1'b1;
        end
      end
      S_JRD: begin
        k_re      = 1'b1;
        k_ra      = anc_r;
        r_re      = 1'b1;
        r_ra      = cur_r;
        state_nxt = S_JRC;
      end
      S_JRC: begin
        kd_nxt    = k_rd;
        rc_nxt    = r_rd;
        k_re      = 1'b1;
        k_ra      = cur_r;
        state_nxt = S_JCMP;
      end
      S_JCMP: begin
        kc_nxt = k_rd;
        if (key_le(kd_r, k_rd, sgn_r)) begin
          j_done = 1'b1;
        end else begin
          state_nxt = S_JWD;
        end
      end
      S_JWD: begin
        k_we      = 1'b1;
        k_wa      = anc_r;
        k_wd      = kc_r;
        r_we      = 1'b1;
        r_wa      = cur_r;
        r_wd      = !rc_r;
        state_nxt = S_JWC;
      end
      S_JWC: begin
        k_we   = 1'b1;
        k_wa   = cur_r;
        k_wd   = kd_r;
        j_done = 1'b1;
        j_swp  = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // advance the request that owns the finished join
    if (j_done) begin
      case (req_r)
        REQ_INSERT: begin
          if (!j_swp || anc_r == '0) begin
            fin = 1'b1;
          end else begin
            cur_nxt   = anc_r;
            idx_nxt   = IW'(anc_r);
            state_nxt = S_DA;
          end
        end
        REQ_EXTRACT: begin
          idx_nxt   = IW'(cur_r >> 1);
          state_nxt = S_EL;
        end
        default: begin
          idx_nxt   = IW'(cur_r) - IW'(1);
          state_nxt = S_BJ;
        end
      endcase
    end

    if (fin) begin
      state_nxt              = S_IDLE;
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = fin_st;
      out_data_nxt.count_out = CAP_W'(cnt_nxt);
      out_data_nxt.key_out   = '0;
      if (fin_st == ST_DONE && req_r == REQ_EXTRACT && state_r != S_IDLE) begin
        out_data_nxt.key_out = 32'(KX'(kout_nxt));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RST;
      sgn_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      sgn_r       <= sgn_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    anc_r      <= anc_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    key_r      <= key_nxt;
    kd_r       <= kd_nxt;
    kc_r       <= kc_nxt;
    kout_r     <= kout_nxt;
    rc_r       <= rc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/whpq_checker.sv
// ----------------------------------------------------------------------------
// whpq_checker
// Port-level checks of the weak heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whpq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input whpq_pkg::out_t out_data
);

  import whpq_pkg::*;

  `WHPQ_ASSERT(a_accept_busy, (start && !busy) |=> (busy || out_valid))
  `WHPQ_ASSERT(a_result_idle, out_valid |-> !busy)
  `WHPQ_ASSERT(a_refused_key, (out_valid && out_data.status != ST_DONE) |-> out_data.key_out == '0)
  `WHPQ_ASSERT(a_empty_count, (out_valid && out_data.status == ST_EMPTY) |-> out_data.count_out == '0)
  `WHPQ_NEVER(a_status_code, out_valid && out_data.status > ST_EMPTY)

endmodule

bind weak_heap_priority_queue whpq_checker u_whpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### test/weak_heap_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weak_heap_priority_queue_checker
// Watches the request, result and register channels of the weak heap queue,
// keeps its own weak heap to predict each result and compares field by field.
// ----------------------------------------------------------------------------
module weak_heap_priority_queue_checker
  import whpq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]     cfg_data,
  output int                   fails,
  output int                   pending
);

  localparam int SLOTS = DEPTH_DEF;

  logic [31:0]      heap_key [SLOTS];
  bit               heap_rev [SLOTS];
  int               held;
  logic [CAP_W-1:0] cap_reg;
  bit               signed_keys;
  out_t             result_q[$];

  function automatic bit key_ordered(logic [31:0] a, logic [31:0] b);
    if (signed_keys) return $signed(a) <= $signed(b);
    return a <= b;
  endfunction

  function automatic bit heap_join(int d, int c);
    logic [31:0] t;
    if (key_ordered(heap_key[d], heap_key[c])) return 1'b1;
    t = heap_key[d];
    heap_key[d] = heap_key[c];
    heap_key[c] = t;
    heap_rev[c] = !heap_rev[c];
    return 1'b0;
  endfunction

  function automatic int dist_parent(int i);
    while (i > 1 && i[0] == heap_rev[i >> 1]) i = i >> 1;
    return i >> 1;
  endfunction

  function automatic int fast_parent(int i);
    while (i[0] == 1'b0) i = i >> 1;
    return i >> 1;
  endfunction

  function automatic out_t heap_request(in_t req);
    out_t r;
    int   n;
    int   lim;
    int   d;
    int   idx;
    int   last;
    r = '0;
    n = held;
    lim = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
    case (req.req_type)
      REQ_INSERT, REQ_LOAD: begin
        if (n >= lim) begin
          r.status = ST_FULL;
        end else begin
          heap_key[n] = req.key_in;
          heap_rev[n] = 1'b0;
          held = n + 1;
          if (req.req_type == REQ_INSERT && n != 0) begin
            if (n[0] == 1'b0) heap_rev[n >> 1] = 1'b0;
            do begin
              d = dist_parent(n);
              if (heap_join(d, n)) break;
              n = d;
            end while (n != 0);
          end
        end
      end
      REQ_EXTRACT: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key_out = heap_key[0];
          n--;
          held = n;
          if (n != 0) begin
            last = 0;
            idx = 1 - heap_rev[0];
            while (idx < n) begin
              last = idx;
              idx = 2 * idx + heap_rev[idx];
            end
            heap_key[0] = heap_key[n];
            idx = last;
            while (idx != 0) begin
              void'(heap_join(0, idx));
              idx = idx >> 1;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) heap_rev[i] = 1'b0;
        for (int i = n - 1; i >= 1; i--) void'(heap_join(fast_parent(i), i));
      end
    endcase
    r.count_out = held[CAP_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      held        = 0;
      cap_reg     = CAP_RST;
      signed_keys = 1'b0;
      fails       = 0;
      result_q.delete();
      pending     = 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data.key_out !== exp_r.key_out) begin
            fails++;
            $display("%0t: key_out expected %h actual %h", $time,
                     exp_r.key_out, out_data.key_out);
          end
          if (out_data.status !== exp_r.status) begin
            fails++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_data.status);
          end
          if (out_data.count_out !== exp_r.count_out) begin
            fails++;
            $display("%0t: count_out expected %0d actual %0d", $time,
                     exp_r.count_out, out_data.count_out);
          end
        end
      end
      if (start && !busy) result_q.push_back(heap_request(in_data));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CAPACITY) cap_reg = cfg_data;
        else if (cfg_index == REG_KEY_SIGNED) signed_keys = cfg_data[0];
      end
      pending = result_q.size();
    end
  end

endmodule

### test/weak_heap_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weak_heap_priority_queue_test
// Drives directed and random insert, extract, load and build transactions
// under several capacity and key order settings, with random gaps.
// ----------------------------------------------------------------------------
module weak_heap_priority_queue_test;
  import whpq_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;
  int                   fails;
  int                   pending;

  weak_heap_priority_queue u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  weak_heap_priority_queue_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [1:0] op, logic [31:0] key, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{req_type: op, key_in: key};
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 75) return $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h8000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    logic [CAP_W-1:0] caps [6];
    bit               sgn  [6];
    int               grow;
    int               r;
    logic [1:0]       op;
    caps = '{11'd1024, 11'd16, 11'd1, 11'd2047, 11'd64, 11'd5};
    sgn  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_CAPACITY, 11'd3);
    write_reg(REG_KEY_SIGNED, 11'd0);
    send(REQ_EXTRACT, 32'h1234_5678, 0);
    send(REQ_BUILD, 32'h0, 0);
    send(REQ_LOAD, 32'h0000_0009, 0);
    send(REQ_BUILD, 32'h0, 1);
    send(REQ_INSERT, 32'hFFFF_FFFF, 0);
    send(REQ_LOAD, 32'h8000_0000, 0);
    send(REQ_INSERT, 32'h0, 2);
    send(REQ_LOAD, 32'h7FFF_FFFF, 0);
    send(REQ_BUILD, 32'h0, 0);
    repeat (4) send(REQ_EXTRACT, 32'h0, 0);
    write_reg(REG_KEY_SIGNED, 11'd1);
    send(REQ_INSERT, 32'h7FFF_FFFF, 0);
    send(REQ_INSERT, 32'hFFFF_FFFF, 0);
    send(REQ_INSERT, 32'h8000_0000, 0);
    write_reg(REG_CAPACITY, 11'd1);
    send(REQ_INSERT, 32'h5, 0);
    send(REQ_EXTRACT, 32'h0, 0);
    write_reg(REG_CAPACITY, 11'd0);
    send(REQ_INSERT, 32'h5, 0);
    send(REQ_LOAD, 32'h6, 0);
    send(REQ_EXTRACT, 32'h0, 0);
    send(REQ_EXTRACT, 32'h0, 0);

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CAPACITY, caps[p]);
      write_reg(REG_KEY_SIGNED, {10'd0, sgn[p]});
      grow = (caps[p] >= 11'd1024) ? 60 : 45;
      for (int k = 0; k < 265; k++) begin
        r = $urandom_range(0, 99);
        if (r < grow) op = REQ_INSERT;
        else if (r < 87) op = REQ_EXTRACT;
        else if (r < 97) op = REQ_LOAD;
        else op = REQ_BUILD;
        if ($urandom_range(0, 99) == 0) drain();
        send(op, pick_key(), pick_gap(p[0] && k < 130));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
